// File: design/hbt_pkg.sv
package hbt_pkg;

    // Item and field geometry
    localparam int SLOTS       = 6;
    localparam int NUM_TILES   = 6;
    localparam int CHANNELS    = 3;
    localparam int HEIGHT_W    = 8;
    localparam int TEXEL_W     = 24;
    localparam int CH_W        = 8;
    localparam int Q_FRAC      = 10;
    localparam int BOUND_W     = 11;
    localparam int BAND_W      = 3 * BOUND_W;

    // Height normalization divider
    localparam int NORM_W      = HEIGHT_W + Q_FRAC;
    localparam int NDIV_STEPS  = NORM_W;

    // Tile weights, Q1.16
    localparam int WFRAC       = 16;
    localparam int WEIGHT_W    = WFRAC + 1;
    localparam int WDIV_STEPS  = WFRAC;
    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = WEIGHT_W'(1) << WFRAC;
    localparam int TOTAL_W     = WEIGHT_W + 2;

    // Blend divider
    localparam int BLEND_STEPS = CH_W;
    localparam int BLEND_NUM_W = WEIGHT_W + CH_W;
    localparam int SUM_W       = CH_W + 3;
    localparam logic [CH_W-1:0] CH_MAX = '1;

    // Queue between front and back
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = BAND_W;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT = 3'd0;
    localparam int REG_BAND_0  = 1;
    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_RESET = 8'd255;
    localparam logic [BAND_W-1:0] BAND_RESET [SLOTS] = '{
        33'd1288071168, 33'd1934307482, 33'd2794455347,
        33'd3436603904, 33'd3868930765, 33'd4296960870
    };

    typedef enum logic [1:0] {
        W_ZERO,
        W_FULL,
        W_DIV
    } wmode_t;

    typedef logic [SLOTS-1:0][TEXEL_W-1:0] texel_vec_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0]           max_height;
        logic [SLOTS-1:0][BAND_W-1:0]  band;
    } cfg_t;

    typedef struct packed {
        logic [SLOTS-1:0][WEIGHT_W-1:0] weight;
        logic [TOTAL_W-1:0]             total;
        texel_vec_t                     texel;
    } blend_item_t;

endpackage

// File: design/hbt_in_if.sv
interface hbt_in_if;
    logic                          valid;
    logic                          ready;
    logic [hbt_pkg::HEIGHT_W-1:0]  height_sample;
    logic [hbt_pkg::TEXEL_W-1:0]   texel_0;
    logic [hbt_pkg::TEXEL_W-1:0]   texel_1;
    logic [hbt_pkg::TEXEL_W-1:0]   texel_2;
    logic [hbt_pkg::TEXEL_W-1:0]   texel_3;
    logic [hbt_pkg::TEXEL_W-1:0]   texel_4;
    logic [hbt_pkg::TEXEL_W-1:0]   texel_5;

    modport source (output valid, height_sample, texel_0, texel_1, texel_2, texel_3,
                    texel_4, texel_5, input ready);
    modport sink (input valid, height_sample, texel_0, texel_1, texel_2, texel_3,
                  texel_4, texel_5, output ready);
endinterface

// File: design/hbt_out_if.sv
interface hbt_out_if;
    logic                      valid;
    logic                      ready;
    logic [hbt_pkg::CH_W-1:0]  red;
    logic [hbt_pkg::CH_W-1:0]  green;
    logic [hbt_pkg::CH_W-1:0]  blue;
    logic                      no_cover;

    modport source (output valid, red, green, blue, no_cover, input ready);
    modport sink (input valid, red, green, blue, no_cover, output ready);
endinterface

// File: design/height_texture_blend_top.sv
// Throughput: one pixel per cycle while nothing stalls; every divider is a pipeline
// of one restoring step per stage (18 for height, 16 for weights, 8 for blending).
// A four-entry queue splits the weight front from the blend back.
// Reset (rst_n, async, low) empties all stages and the queue and loads the
// configuration registers with their documented defaults.
module height_texture_blend_top (
    input  logic                             clk,
    input  logic                             rst_n,
    hbt_in_if.sink                           in_ch,
    hbt_out_if.source                        out_ch,
    input  logic                             cfg_we,
    input  logic [hbt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hbt_pkg::*;

    cfg_t         cfg_reg;
    logic         push_valid;
    logic         push_ready;
    blend_item_t  push_item;
    logic         pop_valid;
    logic         pop_ready;
    blend_item_t  pop_item;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_height <= MAX_HEIGHT_RESET;
            for (int k = 0; k < SLOTS; k++)
                cfg_reg.band[k] <= BAND_RESET[k];
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MAX_HEIGHT)
                cfg_reg.max_height <= cfg_data[HEIGHT_W-1:0];
            for (int k = 0; k < SLOTS; k++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_BAND_0 + k))
                    cfg_reg.band[k] <= cfg_data[BAND_W-1:0];
            end
        end
    end

    hbt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    hbt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    hbt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_ch     (out_ch)
    );

`ifndef NO_ASSERTIONS
    // Front accepts whenever the queue has room
    a_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
        push_ready |-> in_ch.ready)
        else $error("front stalled with queue space");

    // Back stalls only behind an untaken result
    a_back_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && !pop_ready) |-> (out_ch.valid && !out_ch.ready))
        else $error("back stalled without output backpressure");

    // Uncovered pixels are black
    a_no_cover_black: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.no_cover) |->
            (out_ch.red == '0 && out_ch.green == '0 && out_ch.blue == '0))
        else $error("uncovered pixel not black");
`endif

endmodule

// File: design/hbt_front.sv
module hbt_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hbt_pkg::cfg_t         cfg,
    hbt_in_if.sink                in_ch,
    output logic                  push_valid,
    input  logic                  push_ready,
    output hbt_pkg::blend_item_t  push_item
);
    import hbt_pkg::*;

    logic                  adv;
    logic [HEIGHT_W-1:0]   div_val;
    logic [NORM_W-1:0]     norm_num;
    texel_vec_t            tex_in;

    // Normalization divider pipeline
    logic [NDIV_STEPS:0]   nv_reg;
    logic [HEIGHT_W-1:0]   nrem_reg [NDIV_STEPS+1];
    logic [NORM_W-1:0]     nq_reg   [NDIV_STEPS+1];
    texel_vec_t            ntex_reg [NDIV_STEPS+1];
    logic [HEIGHT_W-1:0]   nrem_next [NDIV_STEPS];
    logic [NORM_W-1:0]     nq_next   [NDIV_STEPS];

    // Weight divider pipeline
    logic [WDIV_STEPS:0]   wv_reg;
    wmode_t                wmode_reg [WDIV_STEPS+1][SLOTS];
    logic [BOUND_W-1:0]    wrem_reg  [WDIV_STEPS+1][SLOTS];
    logic [BOUND_W-1:0]    wden_reg  [WDIV_STEPS+1][SLOTS];
    logic [WFRAC-1:0]      wq_reg    [WDIV_STEPS+1][SLOTS];
    texel_vec_t            wtex_reg  [WDIV_STEPS+1];
    wmode_t                wmode_init [SLOTS];
    logic [BOUND_W-1:0]    wrem_init  [SLOTS];
    logic [BOUND_W-1:0]    wden_init  [SLOTS];
    logic [BOUND_W-1:0]    wrem_next  [WDIV_STEPS][SLOTS];
    logic [WFRAC-1:0]      wq_next    [WDIV_STEPS][SLOTS];

    // Freeze the whole front while its last stage waits on a full queue
    assign adv         = !wv_reg[WDIV_STEPS] || push_ready;
    assign in_ch.ready = adv;
    assign push_valid  = wv_reg[WDIV_STEPS];

    assign div_val  = (cfg.max_height == '0) ? HEIGHT_W'(1) : cfg.max_height;
    assign norm_num = {in_ch.height_sample, {Q_FRAC{1'b0}}} + NORM_W'(div_val >> 1);

    assign tex_in[0] = in_ch.texel_0;
    assign tex_in[1] = in_ch.texel_1;
    assign tex_in[2] = in_ch.texel_2;
    assign tex_in[3] = in_ch.texel_3;
    assign tex_in[4] = in_ch.texel_4;
    assign tex_in[5] = in_ch.texel_5;

    // One restoring step per normalization stage
    always_comb
    begin
        logic [HEIGHT_W:0] trial;
        for (int j = 0; j < NDIV_STEPS; j++)
        begin
            trial = {nrem_reg[j], nq_reg[j][NORM_W-1]};
            if (trial >= {1'b0, div_val})
            begin
                nrem_next[j] = HEIGHT_W'(trial - {1'b0, div_val});
                nq_next[j]   = {nq_reg[j][NORM_W-2:0], 1'b1};
            end
            else
            begin
                nrem_next[j] = trial[HEIGHT_W-1:0];
                nq_next[j]   = {nq_reg[j][NORM_W-2:0], 1'b0};
            end
        end
    end

    // Classify each tile against its band
    always_comb
    begin
        logic [NORM_W-1:0] n_val;
        logic [NORM_W-1:0] lo;
        logic [NORM_W-1:0] opt;
        logic [NORM_W-1:0] hi;
        n_val = nq_reg[NDIV_STEPS];
        for (int k = 0; k < SLOTS; k++)
        begin
            lo  = NORM_W'(cfg.band[k][BOUND_W-1:0]);
            opt = NORM_W'(cfg.band[k][2*BOUND_W-1:BOUND_W]);
            hi  = NORM_W'(cfg.band[k][3*BOUND_W-1:2*BOUND_W]);
            wmode_init[k] = W_ZERO;
            wrem_init[k]  = '0;
            wden_init[k]  = '0;
            if (k >= NUM_TILES || n_val < lo || n_val > hi)
                wmode_init[k] = W_ZERO;
            else if (n_val == opt)
                wmode_init[k] = W_FULL;
            else if (n_val < opt)
            begin
                if (k == 0)
                    wmode_init[k] = W_FULL;
                else
                begin
                    wmode_init[k] = W_DIV;
                    wrem_init[k]  = BOUND_W'(n_val - lo);
                    wden_init[k]  = BOUND_W'(opt - lo);
                end
            end
            else
            begin
                if (k == NUM_TILES - 1)
                    wmode_init[k] = W_FULL;
                else
                begin
                    wmode_init[k] = W_DIV;
                    wrem_init[k]  = BOUND_W'(hi - n_val);
                    wden_init[k]  = BOUND_W'(hi - opt);
                end
            end
        end
    end

    // One restoring step per weight stage, all tiles in parallel
    always_comb
    begin
        logic [BOUND_W:0] trial;
        for (int j = 0; j < WDIV_STEPS; j++)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                trial = {wrem_reg[j][k], 1'b0};
                if (trial >= {1'b0, wden_reg[j][k]})
                begin
                    wrem_next[j][k] = BOUND_W'(trial - {1'b0, wden_reg[j][k]});
                    wq_next[j][k]   = {wq_reg[j][k][WFRAC-2:0], 1'b1};
                end
                else
                begin
                    wrem_next[j][k] = trial[BOUND_W-1:0];
                    wq_next[j][k]   = {wq_reg[j][k][WFRAC-2:0], 1'b0};
                end
            end
        end
    end

    // Resolve weights and their total for the queue
    always_comb
    begin
        logic [TOTAL_W-1:0] sum;
        sum = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            unique case (wmode_reg[WDIV_STEPS][k])
                W_ZERO:  push_item.weight[k] = '0;
                W_FULL:  push_item.weight[k] = FULL_WEIGHT;
                W_DIV:   push_item.weight[k] = {1'b0, wq_reg[WDIV_STEPS][k]};
                default: push_item.weight[k] = '0;
            endcase
            sum = sum + TOTAL_W'(push_item.weight[k]);
        end
        push_item.total = sum;
        push_item.texel = wtex_reg[WDIV_STEPS];
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg <= '0;
            wv_reg <= '0;
        end
        else if (adv)
        begin
            nv_reg <= {nv_reg[NDIV_STEPS-1:0], in_ch.valid};
            wv_reg <= {wv_reg[WDIV_STEPS-1:0], nv_reg[NDIV_STEPS]};
        end
    end

    // Advance stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nrem_reg[0] <= '0;
            nq_reg[0]   <= norm_num;
            ntex_reg[0] <= tex_in;
            for (int j = 0; j < NDIV_STEPS; j++)
            begin
                nrem_reg[j+1] <= nrem_next[j];
                nq_reg[j+1]   <= nq_next[j];
                ntex_reg[j+1] <= ntex_reg[j];
            end
            wtex_reg[0] <= ntex_reg[NDIV_STEPS];
            for (int k = 0; k < SLOTS; k++)
            begin
                wmode_reg[0][k] <= wmode_init[k];
                wrem_reg[0][k]  <= wrem_init[k];
                wden_reg[0][k]  <= wden_init[k];
                wq_reg[0][k]    <= '0;
            end
            for (int j = 0; j < WDIV_STEPS; j++)
            begin
                wtex_reg[j+1] <= wtex_reg[j];
                for (int k = 0; k < SLOTS; k++)
                begin
                    wmode_reg[j+1][k] <= wmode_reg[j][k];
                    wrem_reg[j+1][k]  <= wrem_next[j][k];
                    wden_reg[j+1][k]  <= wden_reg[j][k];
                    wq_reg[j+1][k]    <= wq_next[j][k];
                end
            end
        end
    end

endmodule

// File: design/hbt_fifo.sv
module hbt_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  hbt_pkg::blend_item_t  push_item,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output hbt_pkg::blend_item_t  pop_item
);
    import hbt_pkg::*;

    blend_item_t            entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = count_reg != FIFO_CNT_W'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the pushed transaction
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: design/hbt_back.sv
module hbt_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  hbt_pkg::blend_item_t  pop_item,
    hbt_out_if.source             out_ch
);
    import hbt_pkg::*;

    logic                     adv;
    logic                     nc_init;
    logic [TOTAL_W-1:0]       den_init;
    logic [TOTAL_W-1:0]       rem_init [SLOTS][CHANNELS];
    logic [CH_W-1:0]          q_init   [SLOTS][CHANNELS];

    logic [BLEND_STEPS:0]     bv_reg;
    logic                     bnc_reg  [BLEND_STEPS+1];
    logic [TOTAL_W-1:0]       bden_reg [BLEND_STEPS+1];
    logic [TOTAL_W-1:0]       brem_reg [BLEND_STEPS+1][SLOTS][CHANNELS];
    logic [CH_W-1:0]          bq_reg   [BLEND_STEPS+1][SLOTS][CHANNELS];
    logic [TOTAL_W-1:0]       brem_next [BLEND_STEPS][SLOTS][CHANNELS];
    logic [CH_W-1:0]          bq_next   [BLEND_STEPS][SLOTS][CHANNELS];
    logic [CH_W-1:0]          chan_sat  [CHANNELS];

    logic                     out_valid_reg;
    logic [CH_W-1:0]          red_reg;
    logic [CH_W-1:0]          green_reg;
    logic [CH_W-1:0]          blue_reg;
    logic                     no_cover_reg;

    // Hold the back while a finished result is not taken
    assign adv       = !out_valid_reg || out_ch.ready;
    assign pop_ready = adv;

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.red      = red_reg;
    assign out_ch.green    = green_reg;
    assign out_ch.blue     = blue_reg;
    assign out_ch.no_cover = no_cover_reg;

    assign nc_init  = pop_item.total == '0;
    assign den_init = nc_init ? TOTAL_W'(1) : pop_item.total;

    // Form rounded numerators, one lane per tile and channel
    always_comb
    begin
        logic [BLEND_NUM_W-1:0] num;
        logic [CH_W-1:0]        ch;
        for (int k = 0; k < SLOTS; k++)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                ch  = pop_item.texel[k][TEXEL_W-1-CH_W*c -: CH_W];
                num = BLEND_NUM_W'(pop_item.weight[k]) * BLEND_NUM_W'(ch)
                    + BLEND_NUM_W'(pop_item.total >> 1);
                rem_init[k][c] = TOTAL_W'(num[BLEND_NUM_W-1:BLEND_STEPS]);
                q_init[k][c]   = num[BLEND_STEPS-1:0];
            end
        end
    end

    // One restoring step per blend stage
    always_comb
    begin
        logic [TOTAL_W:0] trial;
        for (int j = 0; j < BLEND_STEPS; j++)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    trial = {brem_reg[j][k][c], bq_reg[j][k][c][CH_W-1]};
                    if (trial >= {1'b0, bden_reg[j]})
                    begin
                        brem_next[j][k][c] = TOTAL_W'(trial - {1'b0, bden_reg[j]});
                        bq_next[j][k][c]   = {bq_reg[j][k][c][CH_W-2:0], 1'b1};
                    end
                    else
                    begin
                        brem_next[j][k][c] = trial[TOTAL_W-1:0];
                        bq_next[j][k][c]   = {bq_reg[j][k][c][CH_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Sum terms per channel and saturate
    always_comb
    begin
        logic [SUM_W-1:0] sum;
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum = '0;
            for (int k = 0; k < SLOTS; k++)
                sum = sum + SUM_W'(bq_reg[BLEND_STEPS][k][c]);
            chan_sat[c] = (sum > SUM_W'(CH_MAX)) ? CH_MAX : sum[CH_W-1:0];
        end
    end

    // Advance stage and output valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            bv_reg        <= {bv_reg[BLEND_STEPS-1:0], pop_valid};
            out_valid_reg <= bv_reg[BLEND_STEPS];
        end
    end

    // Advance stage and output payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bnc_reg[0]  <= nc_init;
            bden_reg[0] <= den_init;
            for (int k = 0; k < SLOTS; k++)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    brem_reg[0][k][c] <= rem_init[k][c];
                    bq_reg[0][k][c]   <= q_init[k][c];
                end
            end
            for (int j = 0; j < BLEND_STEPS; j++)
            begin
                bnc_reg[j+1]  <= bnc_reg[j];
                bden_reg[j+1] <= bden_reg[j];
                for (int k = 0; k < SLOTS; k++)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        brem_reg[j+1][k][c] <= brem_next[j][k][c];
                        bq_reg[j+1][k][c]   <= bq_next[j][k][c];
                    end
                end
            end
            red_reg      <= chan_sat[0];
            green_reg    <= chan_sat[1];
            blue_reg     <= chan_sat[2];
            no_cover_reg <= bnc_reg[BLEND_STEPS];
        end
    end

endmodule

// File: tb/sv/hbt_blend_checker.sv
module hbt_blend_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    hbt_in_if                               in_ch,
    hbt_out_if                              out_ch,
    input  logic                            cfg_we,
    input  logic [hbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hbt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              pending_pixels,
    output int                              pixels_checked,
    output int                              uncovered_seen
);
    import hbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            no_cover;
    } pixel_t;

    // Shadow copy of the configuration registers
    logic [HEIGHT_W-1:0] shadow_max_height;
    logic [BAND_W-1:0]   shadow_band [SLOTS];

    pixel_t expected_pixels [$];

    // Triangular weight of one tile, Q1.16
    function automatic logic [63:0] tile_weight(int k, logic [63:0] n);
        logic [63:0] lo;
        logic [63:0] opt;
        logic [63:0] hi;
        lo  = 64'(shadow_band[k][BOUND_W-1:0]);
        opt = 64'(shadow_band[k][2*BOUND_W-1:BOUND_W]);
        hi  = 64'(shadow_band[k][3*BOUND_W-1:2*BOUND_W]);
        if (n < lo || n > hi)
            return 64'd0;
        if (n == opt)
            return 64'd65536;
        if (n < opt)
        begin
            if (k == 0)
                return 64'd65536;
            return ((n - lo) << 16) / (opt - lo);
        end
        if (k == NUM_TILES - 1)
            return 64'd65536;
        return ((hi - n) << 16) / (hi - opt);
    endfunction

    // Blend six texels by their normalized tile weights
    function automatic pixel_t blend_pixel(logic [HEIGHT_W-1:0] h, texel_vec_t tex);
        logic [63:0] divisor;
        logic [63:0] n;
        logic [63:0] w [SLOTS];
        logic [63:0] total;
        logic [63:0] acc [CHANNELS];
        logic [63:0] ch;
        pixel_t      px;
        divisor = (shadow_max_height == 0) ? 64'd1 : 64'(shadow_max_height);
        n = (64'(h) * 1024 + divisor / 2) / divisor;
        total = 0;
        for (int k = 0; k < SLOTS; k++)
        begin
            w[k] = (k < NUM_TILES) ? tile_weight(k, n) : 64'd0;
            total += w[k];
        end
        px = '0;
        if (total == 0)
        begin
            px.no_cover = 1'b1;
            return px;
        end
        for (int c = 0; c < CHANNELS; c++)
            acc[c] = 0;
        for (int k = 0; k < SLOTS; k++)
            for (int c = 0; c < CHANNELS; c++)
            begin
                ch = 64'(tex[k][23 - 8*c -: 8]);
                acc[c] += (w[k] * ch + total / 2) / total;
            end
        px.red   = (acc[0] > 255) ? CH_MAX : acc[0][7:0];
        px.green = (acc[1] > 255) ? CH_MAX : acc[1][7:0];
        px.blue  = (acc[2] > 255) ? CH_MAX : acc[2][7:0];
        return px;
    endfunction

    assign pending_pixels = expected_pixels.size();

    always @(posedge clk or negedge rst_n)
    begin
        texel_vec_t tex;
        pixel_t     want;
        pixel_t     got;
        if (!rst_n)
        begin
            shadow_max_height = MAX_HEIGHT_RESET;
            for (int k = 0; k < SLOTS; k++)
                shadow_band[k] = BAND_RESET[k];
            expected_pixels.delete();
            fail_count     = 0;
            pixels_checked = 0;
            uncovered_seen = 0;
        end
        else
        begin
            // Track register writes
            if (cfg_we)
            begin
                if (cfg_index == REG_MAX_HEIGHT)
                    shadow_max_height = cfg_data[HEIGHT_W-1:0];
                else if (cfg_index >= REG_BAND_0 && cfg_index < REG_BAND_0 + SLOTS)
                    shadow_band[cfg_index - REG_BAND_0] = cfg_data;
            end
            // Predict each accepted input transaction
            if (in_ch.valid && in_ch.ready)
            begin
                tex[0] = in_ch.texel_0;
                tex[1] = in_ch.texel_1;
                tex[2] = in_ch.texel_2;
                tex[3] = in_ch.texel_3;
                tex[4] = in_ch.texel_4;
                tex[5] = in_ch.texel_5;
                expected_pixels.push_back(blend_pixel(in_ch.height_sample, tex));
            end
            // Compare each accepted output transaction
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.red, out_ch.green, out_ch.blue, out_ch.no_cover};
                if (got.no_cover)
                    uncovered_seen++;
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected pixel r=%0d g=%0d b=%0d nc=%0b",
                                 got.red, got.green, got.blue, got.no_cover);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: pixel %0d exp r=%0d g=%0d b=%0d nc=%0b got r=%0d g=%0d b=%0d nc=%0b",
                                     pixels_checked, want.red, want.green, want.blue,
                                     want.no_cover, got.red, got.green, got.blue,
                                     got.no_cover);
                    end
                end
            end
        end
    end
endmodule

// File: tb/sv/testbench.sv
module testbench;
    import hbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending_pixels;
    int pixels_checked;
    int uncovered_seen;

    int  pixels_sent;
    bit  sender_idles;
    bit  sink_idles;
    bit  long_hold_done;
    int  config_sets;

    hbt_in_if  in_ch ();
    hbt_out_if out_ch ();

    height_texture_blend_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hbt_blend_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_pixels (pending_pixels),
        .pixels_checked (pixels_checked),
        .uncovered_seen (uncovered_seen)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Time limit
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // Drive one pixel and hold it until accepted
    task automatic send_pixel(logic [HEIGHT_W-1:0] h, texel_vec_t tex);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.height_sample <= h;
        in_ch.texel_0       <= tex[0];
        in_ch.texel_1       <= tex[1];
        in_ch.texel_2       <= tex[2];
        in_ch.texel_3       <= tex[3];
        in_ch.texel_4       <= tex[4];
        in_ch.texel_5       <= tex[5];
        do
            @(posedge clk);
        while (!in_ch.ready);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_pixel();
        texel_vec_t tex;
        for (int k = 0; k < SLOTS; k++)
            tex[k] = TEXEL_W'($urandom());
        send_pixel(HEIGHT_W'($urandom()), tex);
    endtask

    // Hold the write enable high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // Let the pipeline drain before touching registers
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_pixels != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // Well-formed band most of the time, occasionally a random bit pattern
    function automatic logic [BAND_W-1:0] pick_band();
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] opt;
        logic [BOUND_W-1:0] hi;
        if ($urandom_range(0, 9) == 0)
            return BAND_W'({$urandom(), $urandom()});
        lo  = BOUND_W'($urandom_range(0, 1300));
        opt = lo + BOUND_W'($urandom_range(0, 350));
        hi  = opt + BOUND_W'($urandom_range(0, 350));
        return {hi, opt, lo};
    endfunction

    task automatic load_setting(int sel);
        logic [HEIGHT_W-1:0] mh;
        logic [BAND_W-1:0]   b;
        case (sel)
            0: mh = 8'd1;
            1: mh = 8'd255;
            2: mh = 8'd255;
            3: mh = 8'd200;
            default: mh = HEIGHT_W'($urandom_range(1, 255));
        endcase
        write_reg(REG_MAX_HEIGHT, CFG_DATA_W'(mh));
        for (int k = 0; k < SLOTS; k++)
        begin
            case (sel)
                1: b = '1;
                2: b = '0;
                default: b = pick_band();
            endcase
            write_reg(CFG_IDX_W'(REG_BAND_0 + k), b);
        end
        cfg_we <= 1'b0;
        config_sets++;
    endtask

    // Receiver: random stall bursts plus one long hold-off
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && pixels_sent >= 300)
            begin
                long_hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            else if (sink_idles && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 7);
                out_ch.ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Stimulus
    initial
    begin
        texel_vec_t tex;
        logic [HEIGHT_W-1:0] dir_heights [8];
        int cycles;
        in_ch.valid         = 1'b0;
        in_ch.height_sample = '0;
        in_ch.texel_0       = '0;
        in_ch.texel_1       = '0;
        in_ch.texel_2       = '0;
        in_ch.texel_3       = '0;
        in_ch.texel_4       = '0;
        in_ch.texel_5       = '0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        pixels_sent         = 0;
        sender_idles        = 1'b1;
        sink_idles          = 1'b1;
        long_hold_done      = 1'b0;
        config_sets         = 0;
        rst_n               = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: height extremes and texel extremes on reset bands
        dir_heights = '{8'd0, 8'd255, 8'd1, 8'd51, 8'd77, 8'd128, 8'd200, 8'd230};
        for (int i = 0; i < 8; i++)
        begin
            for (int k = 0; k < SLOTS; k++)
                tex[k] = (i % 2) ? 24'hFFFFFF : 24'h000000;
            send_pixel(dir_heights[i], tex);
        end
        for (int i = 0; i < 6; i++)
        begin
            for (int k = 0; k < SLOTS; k++)
                tex[k] = (k == i) ? 24'hFFFFFF : 24'h0F80F0;
            send_pixel(HEIGHT_W'(i * 50), tex);
        end

        // Height above max with randomly picked bands
        wait_drained();
        load_setting(0);
        for (int i = 0; i < 4; i++)
        begin
            for (int k = 0; k < SLOTS; k++)
                tex[k] = 24'hFFFFFF;
            send_pixel(HEIGHT_W'(i), tex);
        end

        // Random phases across settings
        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            load_setting(p);
            if (p == 7)
            begin
                sender_idles = 1'b0;
                sink_idles   = 1'b0;
            end
            for (int i = 0; i < 200; i++)
                send_random_pixel();
        end

        // Drain the remaining results and report
        in_ch.valid <= 1'b0;
        cycles = 0;
        while (pending_pixels != 0 && cycles < 100000)
        begin
            @(negedge clk);
            cycles++;
        end
        repeat (60) @(negedge clk);

        $display("Sent %0d pixels over %0d register settings; checked %0d results",
                 pixels_sent, config_sets + 1, pixels_checked);
        $display("Uncovered heights seen: %0d, results still outstanding: %0d",
                 uncovered_seen, pending_pixels);
        if (fail_count == 0 && pending_pixels == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: filelist.f
design/hbt_pkg.sv
design/hbt_in_if.sv
design/hbt_out_if.sv
design/hbt_front.sv
design/hbt_fifo.sv
design/hbt_back.sv
design/height_texture_blend_top.sv
tb/sv/hbt_blend_checker.sv
tb/sv/testbench.sv
